FILE: hw/rtl/kruskal_minimum_spanning_tree_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Kruskal spanning tree core
// Checks are compiled in for simulation and left out for synthesis.
// ----------------------------------------------------------------------------
`ifndef KRUSKAL_MINIMUM_SPANNING_TREE_CORE_DEFINES_SVH
`define KRUSKAL_MINIMUM_SPANNING_TREE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// checked only while out of reset
`define KMST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("kmst check failed");
// checked at every edge, reset included
`define KMST_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("kmst check failed");
`else
`define KMST_ASSERT(lbl, prop)
`define KMST_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: hw/rtl/kmst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmst_pkg
// Shared payload types, state encoding and control/status bundles.
// ----------------------------------------------------------------------------
package kmst_pkg;

  localparam int VERT_W = 7;
  localparam int COST_W = 16;

  typedef struct packed {
    logic [VERT_W-1:0] vertex_a;
    logic [VERT_W-1:0] vertex_b;
    logic [COST_W-1:0] edge_cost;
    logic              last_edge;
  } in_item_t;

  typedef struct packed {
    logic [VERT_W-1:0] tree_from;
    logic [VERT_W-1:0] tree_to;
    logic [COST_W-1:0] tree_cost;
    logic              edge_valid;
    logic              last_result;
    logic              overflow;
  } out_item_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_PASS_INIT,
    S_SCAN,
    S_PICK,
    S_FA_RD,
    S_FA_CHK,
    S_FB_RD,
    S_FB_CHK,
    S_EMIT_PREV,
    S_FINAL
  } state_t;

  typedef struct packed {
    logic load;
    logic pass_start;
    logic scan_en;
    logic commit_last;
    logic cur_load_a;
    logic cur_load_b;
    logic pread;
    logic follow;
    logic root_a_save;
    logic union_wr;
    logic pend_load;
    logic out_load_pend;
    logic out_load_empty;
    logic out_last;
    logic run_clear;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic best_found;
    logic cand_ok;
    logic p_is_root;
    logic roots_equal;
    logic pend_valid;
    logic out_free;
  } dp_status_t;

endpackage

FILE: hw/rtl/kmst_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmst_dp
// Edge store, ordered selection scan, union-find table and output register.
// ----------------------------------------------------------------------------
`include "kruskal_minimum_spanning_tree_core_defines.svh"
module kmst_dp #(
  parameter int MAX_EDGES    = 256,
  parameter int MAX_VERTICES = 64,
  parameter int COST_BITS    = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  kmst_pkg::in_item_t  in_data,
  input  logic [6:0]          num_vertices,
  input  kmst_pkg::dp_cmd_t   cmd,
  output kmst_pkg::dp_status_t st,
  output logic                out_valid,
  input  logic                out_ready,
  output kmst_pkg::out_item_t out_data
);
  import kmst_pkg::*;

  localparam int EIW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CNTW = $clog2(MAX_EDGES + 1);
  localparam int VIW  = $clog2(MAX_VERTICES);
  localparam int CW   = (COST_BITS < COST_W) ? COST_BITS : COST_W;
  localparam int EW   = 2 * VERT_W + CW;

  function automatic logic in_rng(input logic [VERT_W-1:0] v, input logic [6:0] n);
    return (v != '0) && (v <= n) && (32'(v) <= MAX_VERTICES);
  endfunction

  // edge store
  logic [EW-1:0]     emem [MAX_EDGES];
  logic [EW-1:0]     erd_r;
  logic [CNTW-1:0]   count_r;
  logic              drop_r;
  logic [CNTW-1:0]   issue_r;
  logic              rv_r;
  logic [EIW-1:0]    ridx_r;

  // selection state
  logic              have_last_r;
  logic [CW-1:0]     last_cost_r;
  logic [EIW-1:0]    last_idx_r;
  logic              best_found_r;
  logic [CW-1:0]     best_cost_r;
  logic [EIW-1:0]    best_idx_r;
  logic [VERT_W-1:0] best_a_r, best_b_r;

  // union-find
  logic [VIW-1:0]          pmem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] pvalid_r;
  logic [VIW-1:0]          prd_r;
  logic                    pval_r;
  logic [VIW-1:0]          cur_r;
  logic [VIW-1:0]          root_a_r;
  logic [VIW-1:0]          pdata;

  // pending result and output register
  logic              pend_valid_r;
  logic [VERT_W-1:0] pend_a_r, pend_b_r;
  logic [CW-1:0]     pend_cost_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic              ld_ok;
  logic              issue_more;
  logic [VERT_W-1:0] e_a, e_b;
  logic [CW-1:0]     e_cost;
  logic              after_last, beats_best;

  assign ld_ok      = in_rng(in_data.vertex_a, num_vertices) &&
                      in_rng(in_data.vertex_b, num_vertices);
  assign issue_more = issue_r < count_r;
  assign e_a        = erd_r[EW-1 -: VERT_W];
  assign e_b        = erd_r[CW +: VERT_W];
  assign e_cost     = erd_r[CW-1:0];
  // next in (cost, arrival) order after the last pick
  assign after_last = !have_last_r || (e_cost > last_cost_r) ||
                      ((e_cost == last_cost_r) && (ridx_r > last_idx_r));
  assign beats_best = !best_found_r || (e_cost < best_cost_r);
  assign pdata      = pval_r ? prd_r : cur_r;

  always_ff @(posedge clk) begin
    if (cmd.load && ld_ok && count_r < CNTW'(MAX_EDGES)) begin
      emem[count_r[EIW-1:0]] <= {in_data.vertex_a, in_data.vertex_b, in_data.edge_cost[CW-1:0]};
    end
    if (cmd.scan_en && issue_more) begin
      erd_r  <= emem[issue_r[EIW-1:0]];
      ridx_r <= issue_r[EIW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      drop_r  <= 1'b0;
    end else if (cmd.run_clear) begin
      count_r <= '0;
      drop_r  <= 1'b0;
    end else if (cmd.load && ld_ok) begin
      if (count_r < CNTW'(MAX_EDGES)) begin
        count_r <= count_r + CNTW'(1);
      end else begin
        drop_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r      <= '0;
      rv_r         <= 1'b0;
      best_found_r <= 1'b0;
      have_last_r  <= 1'b0;
    end else begin
      if (cmd.pass_start || cmd.run_clear) begin
        issue_r      <= '0;
        rv_r         <= 1'b0;
        best_found_r <= 1'b0;
      end else if (cmd.scan_en) begin
        rv_r <= issue_more;
        if (issue_more) begin
          issue_r <= issue_r + CNTW'(1);
        end
        if (rv_r && after_last && beats_best) begin
          best_found_r <= 1'b1;
        end
      end
      if (cmd.run_clear) begin
        have_last_r <= 1'b0;
      end else if (cmd.commit_last) begin
        have_last_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_en && rv_r && after_last && beats_best) begin
      best_cost_r <= e_cost;
      best_idx_r  <= ridx_r;
      best_a_r    <= e_a;
      best_b_r    <= e_b;
    end
    if (cmd.commit_last) begin
      last_cost_r <= best_cost_r;
      last_idx_r  <= best_idx_r;
    end
  end

  // parent table; an entry without its valid bit is its own parent
  always_ff @(posedge clk) begin
    if (cmd.union_wr) begin
      pmem[cur_r] <= root_a_r;
    end
    if (cmd.pread) begin
      prd_r <= pmem[cur_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvalid_r <= '0;
    end else if (cmd.run_clear) begin
      pvalid_r <= '0;
    end else if (cmd.union_wr) begin
      pvalid_r[cur_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pread) begin
      pval_r <= pvalid_r[cur_r];
    end
    if (cmd.cur_load_a) begin
      cur_r <= VIW'(best_a_r - VERT_W'(1));
    end else if (cmd.cur_load_b) begin
      cur_r <= VIW'(best_b_r - VERT_W'(1));
    end else if (cmd.follow) begin
      cur_r <= pdata;
    end
    if (cmd.root_a_save) begin
      root_a_r <= cur_r;
    end
    if (cmd.pend_load) begin
      pend_a_r    <= best_a_r;
      pend_b_r    <= best_b_r;
      pend_cost_r <= best_cost_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.run_clear) begin
        pend_valid_r <= 1'b0;
      end else if (cmd.pend_load) begin
        pend_valid_r <= 1'b1;
      end
      if (cmd.out_load_pend || cmd.out_load_empty) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load_pend) begin
      out_data_r.tree_from   <= pend_a_r;
      out_data_r.tree_to     <= pend_b_r;
      out_data_r.tree_cost   <= COST_W'(pend_cost_r);
      out_data_r.edge_valid  <= 1'b1;
      out_data_r.last_result <= cmd.out_last;
      out_data_r.overflow    <= drop_r;
    end else if (cmd.out_load_empty) begin
      out_data_r.tree_from   <= '0;
      out_data_r.tree_to     <= '0;
      out_data_r.tree_cost   <= '0;
      out_data_r.edge_valid  <= 1'b0;
      out_data_r.last_result <= 1'b1;
      out_data_r.overflow    <= drop_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign st.scan_done   = !issue_more && !rv_r;
  assign st.best_found  = best_found_r;
  assign st.cand_ok     = in_rng(best_a_r, num_vertices) && in_rng(best_b_r, num_vertices) &&
                          (best_a_r != best_b_r);
  assign st.p_is_root   = pdata == cur_r;
  assign st.roots_equal = cur_r == root_a_r;
  assign st.pend_valid  = pend_valid_r;
  assign st.out_free    = !out_valid_r || out_ready;

  `KMST_ASSERT(a_issue_bound, issue_r <= count_r)
  `KMST_ASSERT(a_union_distinct, cmd.union_wr |-> !st.roots_equal)
  `KMST_ASSERT(a_clear_empties, cmd.run_clear |=> (count_r == '0 && pvalid_r == '0))
  `KMST_ASSERT(a_out_not_overwritten, (cmd.out_load_pend || cmd.out_load_empty) |-> st.out_free)
endmodule

FILE: hw/rtl/kmst_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmst_ctrl
// Sequencer: edge loading, selection passes, root walks and result release.
// ----------------------------------------------------------------------------
module kmst_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_last,
  output logic                 in_ready,
  input  kmst_pkg::dp_status_t st,
  output kmst_pkg::dp_cmd_t    cmd
);
  import kmst_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD:      if (in_valid && in_last) state_nxt = S_PASS_INIT;
      S_PASS_INIT: state_nxt = S_SCAN;
      S_SCAN:      if (st.scan_done) state_nxt = S_PICK;
      S_PICK: begin
        priority if (!st.best_found) state_nxt = S_FINAL;
        else if (!st.cand_ok)        state_nxt = S_PASS_INIT;
        else                         state_nxt = S_FA_RD;
      end
      S_FA_RD:     state_nxt = S_FA_CHK;
      S_FA_CHK:    state_nxt = st.p_is_root ? S_FB_RD : S_FA_RD;
      S_FB_RD:     state_nxt = S_FB_CHK;
      S_FB_CHK: begin
        priority if (!st.p_is_root) state_nxt = S_FB_RD;
        else if (st.roots_equal)    state_nxt = S_PASS_INIT;
        else                        state_nxt = S_EMIT_PREV;
      end
      S_EMIT_PREV: if (!st.pend_valid || st.out_free) state_nxt = S_PASS_INIT;
      S_FINAL:     if (st.out_free) state_nxt = S_LOAD;
      default:     state_nxt = S_LOAD;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_PASS_INIT: cmd.pass_start = 1'b1;
      S_SCAN:      cmd.scan_en = 1'b1;
      S_PICK: begin
        cmd.commit_last = st.best_found;
        cmd.cur_load_a  = st.best_found && st.cand_ok;
      end
      S_FA_RD:     cmd.pread = 1'b1;
      S_FA_CHK: begin
        cmd.root_a_save = st.p_is_root;
        cmd.cur_load_b  = st.p_is_root;
        cmd.follow      = !st.p_is_root;
      end
      S_FB_RD:     cmd.pread = 1'b1;
      S_FB_CHK: begin
        cmd.follow   = !st.p_is_root;
        cmd.union_wr = st.p_is_root && !st.roots_equal;
      end
      S_EMIT_PREV: begin
        if (!st.pend_valid) begin
          cmd.pend_load = 1'b1;
        end else if (st.out_free) begin
          cmd.pend_load     = 1'b1;
          cmd.out_load_pend = 1'b1;
        end
      end
      S_FINAL: begin
        if (st.out_free) begin
          cmd.out_load_pend  = st.pend_valid;
          cmd.out_load_empty = !st.pend_valid;
          cmd.out_last       = 1'b1;
          cmd.run_clear      = 1'b1;
        end
      end
      default: ;
    endcase
  end
endmodule

FILE: hw/rtl/kruskal_minimum_spanning_tree_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kruskal_minimum_spanning_tree_core
// Minimum spanning forest of an edge list, results streamed in cost order.
// ----------------------------------------------------------------------------
// Usage:
//  - in_*: one edge per transfer. Edges with an endpoint outside
//    1..num_vertices are ignored; past MAX_EDGES stored edges, the rest are
//    dropped and the overflow bit of every result of the run is set.
//  - The edge with last_edge set is stored too and starts the computation;
//    in_ready stays low until the run's final result is loaded for output.
//  - out_*: accepted tree edges in ascending cost (arrival order on ties),
//    last_result on the final one. With no accepted edge, one item with
//    edge_valid low and last_result high is sent.
//  - cfg_*: writes num_vertices (reset value 64); always ready, and to be
//    written only between runs or between edges.
// Operation: loading accepts one edge per cycle. The computation selects
//  edges by repeated scans of the edge store (one read port, one entry a
//  cycle), with one pass per stored edge plus a closing pass; each pass
//  that picks a valid candidate walks both endpoints to their roots in the
//  parent table, and each accepted edge goes through the pending register.
// A stalled receiver holds the output register; the block keeps working
//  until a further result needs the register, then waits.
// Reset empties the store, clears the overflow flag and the union-find table
//  (valid bits) at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module kruskal_minimum_spanning_tree_core #(
  parameter int MAX_EDGES    = 256,
  parameter int MAX_VERTICES = 64,
  parameter int COST_BITS    = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  kmst_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output kmst_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [6:0]          cfg_data
);
  import kmst_pkg::*;

  // vertex count register
  logic [6:0] num_vertices_r;

  dp_cmd_t    cmd;
  dp_status_t st;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_vertices_r <= 7'd64;
    end else if (cfg_valid) begin
      num_vertices_r <= cfg_data;
    end
  end

  // sequencer
  kmst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_edge),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // store, scan, union-find and output register
  kmst_dp #(
    .MAX_EDGES    (MAX_EDGES),
    .MAX_VERTICES (MAX_VERTICES),
    .COST_BITS    (COST_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_data      (in_data),
    .num_vertices (num_vertices_r),
    .cmd          (cmd),
    .st           (st),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );
endmodule
